FILE: hdl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication under a synchronous reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: hdl/xrwg_pkg.sv
package xrwg_pkg;

   localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;

   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_MUL_LL = 3'd2;
   localparam logic [2:0] OP_MUL_HL = 3'd3;
   localparam logic [2:0] OP_MUL_LH = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic       use_b;
      logic [1:0] word_idx;
      logic       gen;
   } cmd_type;

endpackage

FILE: hdl/xrwg_controller.sv
module xrwg_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output xrwg_pkg::cmd_type cmd
);
   import xrwg_pkg::*;

   localparam logic [2:0] ST_ADD    = 3'd0;
   localparam logic [2:0] ST_MUL_LL = 3'd1;
   localparam logic [2:0] ST_MUL_HL = 3'd2;
   localparam logic [2:0] ST_MUL_LH = 3'd3;
   localparam logic [2:0] ST_RUN    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       use_b_ff, use_b_in;
   logic [1:0] word_ff, word_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       fire;

   assign req_tready = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_tready);
   assign fire       = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      use_b_in     = use_b_ff;
      word_in      = word_ff;
      cmd.op       = OP_NONE;
      cmd.use_b    = use_b_ff;
      cmd.word_idx = word_ff;
      cmd.gen      = fire;
      case (state_ff)
         ST_ADD: begin
            cmd.op   = OP_ADD;
            state_in = ST_MUL_LL;
         end
         ST_MUL_LL: begin
            cmd.op   = OP_MUL_LL;
            state_in = ST_MUL_HL;
         end
         ST_MUL_HL: begin
            cmd.op   = OP_MUL_HL;
            state_in = ST_MUL_LH;
         end
         ST_MUL_LH: begin
            cmd.op = OP_MUL_LH;
            if (!use_b_ff) begin
               use_b_in = 1'b1;
               state_in = ST_MUL_LL;
            end else begin
               use_b_in = 1'b0;
               word_in  = word_ff + 2'd1;
               state_in = (word_ff == 2'd3) ? ST_RUN : ST_ADD;
            end
         end
         ST_RUN: begin
            cmd.op = OP_NONE;
         end
         default: begin
            state_in = ST_ADD;
         end
      endcase
      if (csr_wen) begin
         state_in = ST_ADD;
         use_b_in = 1'b0;
         word_in  = 2'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ADD;
         use_b_ff     <= 1'b0;
         word_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         use_b_ff     <= use_b_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/xrwg_datapath.sv
module xrwg_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wen,
   input  logic [63:0]       csr_wdata,
   input  xrwg_pkg::cmd_type cmd,
   input  logic [3:0]        req_count,
   input  logic              req_last,
   output logic [63:0]       rsp_word,
   output logic [3:0]        rsp_count,
   output logic              rsp_last
);
   import xrwg_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] s_ff [4];
   logic [63:0] s_in [4];
   logic [63:0] word_ff, word_in;
   logic [3:0]  count_ff;
   logic        last_ff;

   logic [63:0] mul_const;
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;
   logic [63:0] sum_acc, sum_prod, mix_t;
   logic [63:0] out_sum, out_res, t17, g2, g3, g1, g0;

   assign mul_const = cmd.use_b ? MIX_MUL_B : MIX_MUL_A;
   assign mul_x     = (cmd.op == OP_MUL_HL) ? z_ff[63:32] : z_ff[31:0];
   assign mul_y     = (cmd.op == OP_MUL_LH) ? mul_const[63:32] : mul_const[31:0];
   assign mul_p     = 64'(mul_x) * 64'(mul_y);
   assign sum_acc   = acc_ff + GOLDEN_STEP;
   assign sum_prod  = prod_ff + {mul_p[31:0], 32'h0};
   assign mix_t     = cmd.use_b ? (sum_prod ^ (sum_prod >> 31)) : (sum_prod ^ (sum_prod >> 27));

   assign out_sum = s_ff[0] + s_ff[3];
   assign out_res = {out_sum[40:0], out_sum[63:41]} + s_ff[0];
   assign t17     = {s_ff[1][46:0], 17'h0};
   assign g2      = s_ff[2] ^ s_ff[0];
   assign g3      = s_ff[3] ^ s_ff[1];
   assign g1      = s_ff[1] ^ g2;
   assign g0      = s_ff[0] ^ g3;

   always_comb begin
      acc_in  = acc_ff;
      z_in    = z_ff;
      prod_in = prod_ff;
      for (int k = 0; k < 4; k++) begin
         s_in[k] = s_ff[k];
      end
      case (cmd.op)
         OP_ADD: begin
            acc_in = sum_acc;
            z_in   = sum_acc ^ (sum_acc >> 30);
         end
         OP_MUL_LL: begin
            prod_in = mul_p;
         end
         OP_MUL_HL: begin
            prod_in = sum_prod;
         end
         OP_MUL_LH: begin
            if (cmd.use_b) begin
               s_in[cmd.word_idx] = mix_t;
            end else begin
               z_in = mix_t;
            end
         end
         default: begin
         end
      endcase
      if (cmd.gen && (req_count != 4'd0)) begin
         s_in[0] = g0;
         s_in[1] = g1;
         s_in[2] = g2 ^ t17;
         s_in[3] = {g3[18:0], g3[63:19]};
      end
      if (csr_wen) begin
         acc_in = csr_wdata;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         word_in[8*i +: 8] = (req_count > 4'(i)) ? out_res[8*i +: 8] : 8'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 64'h0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff    <= z_in;
      prod_ff <= prod_in;
      for (int k = 0; k < 4; k++) begin
         s_ff[k] <= s_in[k];
      end
      if (cmd.gen) begin
         word_ff  <= word_in;
         count_ff <= req_count;
         last_ff  <= req_last;
      end
   end

   assign rsp_word  = word_ff;
   assign rsp_count = count_ff;
   assign rsp_last  = last_ff;

endmodule

FILE: hdl/xoshiro256pp_random_word_generator_unit.sv
// xoshiro256++ word generator. Each request beat yields one response beat carrying the
// next generator word with only its low byte_count bytes kept; a count of zero returns a
// zero word without advancing, a count above eight returns the full word. Once seeded the
// unit takes one request per cycle while the response side keeps up; a response word that
// waits holds req_tready low, and the next request gets in in the cycle that word leaves.
// After reset, and after every seed write, the state is reloaded by four splitmix64 steps
// on a shared 32x32 multiplier, during which req_tready stays low. A seed write restarts
// that reload at once.
module xoshiro256pp_random_word_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] byte_count, [7:4] zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] random_word, [67:64] valid_bytes, [71:68] zero
   output logic        rsp_tlast
);
   import xrwg_pkg::*;

   cmd_type     cmd;
   logic [63:0] rsp_word;
   logic [3:0]  rsp_count;

   xrwg_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   xrwg_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .req_count (req_tdata[3:0]),
      .req_last  (req_tlast),
      .rsp_word  (rsp_word),
      .rsp_count (rsp_count),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'h0, rsp_count, rsp_word};

endmodule

FILE: hdl/xrwg_checker.sv
`include "assert_macros.svh"

module xrwg_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_wen,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic        req_fire;
   logic [3:0]  req_count;
   logic [3:0]  rsp_count;
   logic [63:0] rsp_word;
   assign req_fire  = req_tvalid && req_tready;
   assign req_count = req_tdata[3:0];
   assign rsp_count = rsp_tdata[67:64];
   assign rsp_word  = rsp_tdata[63:0];

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_reseed_blocks, clock, reset, csr_wen, !req_tready)
   `ASSERT_NEXT(a_echo_count, clock, reset, req_fire, rsp_tvalid && rsp_count == $past(req_count))
   `ASSERT_NEXT(a_echo_last, clock, reset, req_fire, rsp_tlast == $past(req_tlast))
   `ASSERT_NEXT(a_zero_count, clock, reset, req_fire && (req_count == 4'd0), rsp_word == 64'h0)

endmodule

bind xoshiro256pp_random_word_generator_unit xrwg_checker u_xrwg_checker (.*);

FILE: sim/tb_xoshiro256pp_random_word_generator_unit.sv
module tb_xoshiro256pp_random_word_generator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] SM_INCREMENT = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] SM_MUL_1     = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] SM_MUL_2     = 64'h94D049BB133111EB;
   localparam int          WORD_BYTES   = 8;
   localparam int          HOLD_AT_WORD = 100;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          CYCLE_LIMIT  = 200000;

   typedef struct {
      bit          is_seed;
      logic [63:0] seed;
      logic [3:0]  byte_count;
      logic        last;
      int          gap;
   } request_beat_type;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  byte_count;
      logic        last;
   } word_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_wen    = 1'b0;
   logic [63:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [3:0] byte_count, [7:4] zero
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [63:0] random_word, [67:64] valid_bytes, [71:68] zero
   logic        rsp_tlast;

   request_beat_type request_beats[$];
   word_beat_type    expected_words[$];
   logic [63:0]      gen_s [4];
   request_beat_type on_bus;
   int               sender_gap_max = 9;
   int               gap_count      = 0;
   int               stall_left     = 0;
   int               words_checked  = 0;
   bit               hold_off       = 1'b0;
   bit               hold_done      = 1'b0;
   int               hold_count     = 0;
   int               cycle_count    = 0;
   int               errors         = 0;

   xoshiro256pp_random_word_generator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] rotl(logic [63:0] v, int r);
      return (v << r) | (v >> (64 - r));
   endfunction

   function automatic void reload_state(logic [63:0] value);
      logic [63:0] acc;
      logic [63:0] z;
      int          k;
      acc = value;
      for (k = 0; k < 4; k++) begin
         acc = acc + SM_INCREMENT;
         z = acc;
         z = (z ^ (z >> 30)) * SM_MUL_1;
         z = (z ^ (z >> 27)) * SM_MUL_2;
         gen_s[k] = z ^ (z >> 31);
      end
   endfunction

   function automatic word_beat_type next_word(logic [3:0] byte_count, logic last);
      word_beat_type r;
      logic [63:0]   t;
      int            n;
      r.word       = '0;
      r.byte_count = byte_count;
      r.last       = last;
      if (byte_count != 0) begin
         n = (byte_count > WORD_BYTES) ? WORD_BYTES : byte_count;
         r.word = rotl(gen_s[0] + gen_s[3], 23) + gen_s[0];
         t = gen_s[1] << 17;
         gen_s[2] = gen_s[2] ^ gen_s[0];
         gen_s[3] = gen_s[3] ^ gen_s[1];
         gen_s[1] = gen_s[1] ^ gen_s[2];
         gen_s[0] = gen_s[0] ^ gen_s[3];
         gen_s[2] = gen_s[2] ^ t;
         gen_s[3] = rotl(gen_s[3], 45);
         if (n < WORD_BYTES)
            r.word = r.word & ((64'd1 << (8 * n)) - 64'd1);
      end
      return r;
   endfunction

   function automatic void add_item(int byte_count, bit last);
      request_beat_type b;
      b.is_seed    = 1'b0;
      b.seed       = '0;
      b.byte_count = byte_count[3:0];
      b.last       = last;
      b.gap        = $urandom_range(0, sender_gap_max);
      request_beats.push_back(b);
   endfunction

   function automatic void add_seed(logic [63:0] value);
      request_beat_type b;
      b.is_seed    = 1'b1;
      b.seed       = value;
      b.byte_count = '0;
      b.last       = 1'b0;
      b.gap        = 0;
      request_beats.push_back(b);
   endfunction

   // request driver: seed writes wait until every word has come back
   always @(posedge clock) begin
      logic valid_n;
      logic wen_n;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_wen    <= 1'b0;
         gap_count = 0;
      end else begin
         valid_n = req_tvalid;
         wen_n   = 1'b0;
         if (req_tvalid && req_tready) begin
            expected_words.push_back(next_word(on_bus.byte_count, on_bus.last));
            valid_n = 1'b0;
         end
         if (!valid_n && !csr_wen && request_beats.size() > 0) begin
            if (request_beats[0].is_seed) begin
               if (expected_words.size() == 0) begin
                  on_bus = request_beats.pop_front();
                  reload_state(on_bus.seed);
                  csr_wdata <= on_bus.seed;
                  wen_n = 1'b1;
               end
            end else if (gap_count < request_beats[0].gap) begin
               gap_count++;
            end else begin
               on_bus = request_beats.pop_front();
               gap_count = 0;
               req_tdata <= {4'b0000, on_bus.byte_count};
               req_tlast <= on_bus.last;
               valid_n = 1'b1;
            end
         end
         req_tvalid <= valid_n;
         csr_wen    <= wen_n;
      end
   end

   // response monitor
   always @(posedge clock) begin
      logic          ready_n;
      word_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         ready_n = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected beat, actual data %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata[63:0] !== want.word) begin
                  $display("%0t: random_word expected %h actual %h",
                           $time, want.word, rsp_tdata[63:0]);
                  errors++;
               end
               if (rsp_tdata[67:64] !== want.byte_count) begin
                  $display("%0t: valid_bytes expected %0d actual %0d",
                           $time, want.byte_count, rsp_tdata[67:64]);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_word expected %b actual %b",
                           $time, want.last, rsp_tlast);
                  errors++;
               end
            end
            words_checked <= words_checked + 1;
            stall_left = (words_checked % 150 < 50) ? 0 : $urandom_range(0, 9);
            ready_n = 1'b0;
         end
         if (hold_off) begin
            ready_n = 1'b0;
         end else if (!ready_n) begin
            if (stall_left > 0)
               stall_left--;
            else
               ready_n = 1'b1;
         end
         rsp_tready <= ready_n;
      end
   end

   // hold off the response side once, long enough to back up the request side
   always @(posedge clock) begin
      if (reset) begin
         hold_off   <= 1'b0;
         hold_count <= 0;
      end else if (hold_off) begin
         if (hold_count == HOLD_CYCLES) begin
            hold_off  <= 1'b0;
            hold_done <= 1'b1;
         end else begin
            hold_count <= hold_count + 1;
         end
      end else if (!hold_done && words_checked >= HOLD_AT_WORD) begin
         hold_off <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int p;
      int n;
      int c;
      int bytes_left;
      reload_state(64'd0);

      for (c = 0; c < 16; c++)
         add_item(c, c[0]);
      add_item(8, 1'b1);
      add_item(0, 1'b0);
      add_seed(64'hFFFF_FFFF_FFFF_FFFF);
      add_item(8, 1'b0);
      add_item(1, 1'b1);
      add_item(0, 1'b1);
      add_seed(64'd0);
      add_item(8, 1'b0);
      add_item(7, 1'b1);
      add_seed(64'h8000_0000_0000_0001);
      add_item(15, 1'b0);
      add_item(2, 1'b1);

      for (p = 0; p < 4; p++) begin
         sender_gap_max = (p == 2) ? 0 : 9;
         if (p > 0)
            add_seed({$urandom, $urandom});
         n = 0;
         while (n < 110) begin
            if ($urandom_range(0, 6) == 0) begin
               add_item($urandom_range(0, 15), 1'($urandom_range(0, 1)));
               n++;
            end else begin
               bytes_left = $urandom_range(1, 40);
               while (bytes_left > 0) begin
                  add_item((bytes_left > WORD_BYTES) ? WORD_BYTES : bytes_left,
                           bytes_left <= WORD_BYTES);
                  bytes_left -= WORD_BYTES;
                  n++;
               end
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (request_beats.size() > 0 || req_tvalid || expected_words.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (errors == 0 && expected_words.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/xrwg_pkg.sv
hdl/xrwg_controller.sv
hdl/xrwg_datapath.sv
hdl/xoshiro256pp_random_word_generator_unit.sv
hdl/xrwg_checker.sv
sim/tb_xoshiro256pp_random_word_generator_unit.sv
